// ===== rtl/core/tsp_pkg.sv =====
// Shared types, constants and the byte-to-symbol table of the extent-table size parser.
package tsp_pkg;

    localparam int ENTRY_BITS  = 16;
    localparam int SECTOR_BASE = 512;

    typedef logic [ENTRY_BITS-1:0] entry_t;
    typedef logic [63:0]           val_t;
    typedef logic [3:0]            sym_t;
    typedef logic [1:0]            field_t;

    // Symbol codes of the alphabet "0123456789-,.; "
    localparam sym_t SYM_NINE  = 4'd9;
    localparam sym_t SYM_COMMA = 4'd11;
    localparam sym_t SYM_DOT   = 4'd12;
    localparam sym_t SYM_SEMI  = 4'd13;

    localparam field_t FIELD_SIZE   = 2'd0;
    localparam field_t FIELD_SECOND = 2'd1;
    localparam field_t FIELD_THIRD  = 2'd2;
    localparam field_t FIELD_LAST   = 2'd3;

    localparam int SYMS_PER_DIGIT = 15;
    localparam int PAIR_LIMIT     = SYMS_PER_DIGIT * SYMS_PER_DIGIT;

    typedef enum logic {
        CFG_SECTOR_SIZE_CODE = 1'b0,
        CFG_TARGET_ENTRY     = 1'b1
    } cfg_idx_t;

    // Per-symbol decode from one lane
    typedef struct packed {
        logic   is_term;
        logic   is_dot;
        logic   is_digit;
        sym_t   digit;
        field_t field_next;
    } lane_out_t;

    // Parse stage to addend stage
    typedef struct packed {
        logic       clr;
        logic       emit;
        logic       found;
        logic [1:0] sec_cnt;
        val_t       diff_a;
        val_t       diff_b;
    } add_req_t;

    // Upper symbol in [7:4], lower symbol in [3:0]
    typedef logic [7:0] pair_tab_t [256];

    function automatic pair_tab_t build_pair_tab();
        pair_tab_t t;
        for (int i = 0; i < 256; i++) begin
            if (i < PAIR_LIMIT) begin
                t[i] = {4'(i / SYMS_PER_DIGIT), 4'(i % SYMS_PER_DIGIT)};
            end else begin
                t[i] = 8'h00;
            end
        end
        return t;
    endfunction

    localparam pair_tab_t PAIR_TAB = build_pair_tab();

endpackage

// ===== rtl/core/tsp_lane.sv =====
// One symbol lane: classifies a symbol and advances the field number.
module tsp_lane (
    input  tsp_pkg::sym_t      sym,
    input  tsp_pkg::field_t    field,
    output tsp_pkg::lane_out_t lane
);

    logic is_semi;

    always_comb begin
        is_semi       = (sym == tsp_pkg::SYM_SEMI);
        lane.is_dot   = (sym == tsp_pkg::SYM_DOT);
        lane.is_term  = (sym == tsp_pkg::SYM_COMMA) || lane.is_dot;
        lane.is_digit = !lane.is_term && !is_semi;
        // non-digit symbols accumulate as zero
        lane.digit    = (sym <= tsp_pkg::SYM_NINE) ? sym : '0;
        if (lane.is_term) begin
            lane.field_next = tsp_pkg::FIELD_SIZE;
        end else if (is_semi && (field != tsp_pkg::FIELD_LAST)) begin
            lane.field_next = field + 2'd1;
        end else begin
            lane.field_next = field;
        end
    end

endmodule

// ===== rtl/core/tsp_parse.sv =====
// Parse stage: two symbol lanes per byte, merge of their effects, entry state registers.
module tsp_parse (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_table_byte,
    input  logic              s_first_byte,
    input  logic              s_last_byte,
    input  logic [15:0]       target_entry,
    output logic              req_valid,
    output tsp_pkg::add_req_t req,
    input  logic              req_take
);

    logic              finished_reg, finished_next;
    tsp_pkg::entry_t   entry_count_reg, entry_count_next;
    tsp_pkg::field_t   field_number_reg, field_number_next;
    tsp_pkg::val_t     second_value_reg, second_value_next;
    tsp_pkg::val_t     third_value_reg, third_value_next;
    logic              digit_seen_reg, digit_seen_next;
    logic              req_valid_reg, req_valid_next;
    tsp_pkg::add_req_t req_reg, req_next;

    logic              fin_e, ds_e, ds1;
    tsp_pkg::entry_t   ec_e, ec1, tgt;
    tsp_pkg::field_t   fn_e, fn1;
    tsp_pkg::val_t     sv_e, tv_e, sv_base, tv_base, sv1, tv1;
    logic [7:0]        pair;
    tsp_pkg::sym_t     sym_hi, sym_lo;
    tsp_pkg::lane_out_t l0, l1;
    logic              act, m0, m1, ec_inc, hi_in, hi_end, lo_in, lo_cnt;
    logic              h_sec, h_thd, l_sec, l_thd, hclr, lclr;
    logic              hi_sec, hi_diff, lo_sec, lo_diff, found, accept;

    // base*10^n plus up to two digits, shift-add only
    function automatic tsp_pkg::val_t field_update(
        input tsp_pkg::val_t base,
        input logic          use_hi,
        input logic          use_lo,
        input tsp_pkg::sym_t dh,
        input tsp_pkg::sym_t dl
    );
        tsp_pkg::val_t x10;
        tsp_pkg::val_t x100;
        logic [6:0]    two_digits;
        x10        = (base << 3) + (base << 1);
        x100       = (base << 6) + (base << 5) + (base << 2);
        two_digits = (7'(dh) << 3) + (7'(dh) << 1) + 7'(dl);
        if (use_hi && use_lo) begin
            return x100 + tsp_pkg::val_t'(two_digits);
        end else if (use_hi) begin
            return x10 + tsp_pkg::val_t'(dh);
        end else if (use_lo) begin
            return x10 + tsp_pkg::val_t'(dl);
        end
        return base;
    endfunction

    tsp_lane u_lane_hi (.sym(sym_hi), .field(fn_e), .lane(l0));
    tsp_lane u_lane_lo (.sym(sym_lo), .field(fn1),  .lane(l1));

    assign s_ready   = !req_valid_reg || req_take;
    assign accept    = s_valid && s_ready;
    assign req_valid = req_valid_reg;
    assign req       = req_reg;

    always_comb begin
        // first byte restarts from a clean state
        fin_e  = s_first_byte ? 1'b0 : finished_reg;
        ec_e   = s_first_byte ? '0 : entry_count_reg;
        fn_e   = s_first_byte ? tsp_pkg::FIELD_SIZE : field_number_reg;
        sv_e   = s_first_byte ? '0 : second_value_reg;
        tv_e   = s_first_byte ? '0 : third_value_reg;
        ds_e   = s_first_byte ? 1'b0 : digit_seen_reg;

        pair   = tsp_pkg::PAIR_TAB[s_table_byte];
        sym_hi = pair[7:4];
        sym_lo = pair[3:0];
        tgt    = tsp_pkg::entry_t'(target_entry);
        act    = !fin_e;

        // upper symbol
        m0     = (ec_e == tgt);
        hi_in  = act && m0;
        ec_inc = act && !m0 && (sym_hi == tsp_pkg::SYM_DOT);
        ec1    = ec_inc ? ec_e + tsp_pkg::entry_t'(1) : ec_e;
        m1     = m0 || (ec_inc && (ec1 == tgt));
        hi_end = hi_in && l0.is_dot;
        fn1    = hi_in ? l0.field_next : fn_e;
        ds1    = ds_e || (hi_in && l0.is_digit);

        // lower symbol, dropped when the upper one closed the entry
        lo_in  = act && !hi_end && m1;
        lo_cnt = act && !m1 && (sym_lo == tsp_pkg::SYM_DOT);

        h_sec  = hi_in && l0.is_digit && (fn_e == tsp_pkg::FIELD_SECOND);
        h_thd  = hi_in && l0.is_digit && (fn_e == tsp_pkg::FIELD_THIRD);
        l_sec  = lo_in && l1.is_digit && (fn1 == tsp_pkg::FIELD_SECOND);
        l_thd  = lo_in && l1.is_digit && (fn1 == tsp_pkg::FIELD_THIRD);
        hclr   = hi_in && l0.is_term;
        lclr   = lo_in && l1.is_term;

        sv_base = hclr ? '0 : sv_e;
        tv_base = hclr ? '0 : tv_e;
        sv1     = field_update(sv_base, h_sec, 1'b0, l0.digit, l1.digit);
        tv1     = field_update(tv_base, h_thd, 1'b0, l0.digit, l1.digit);

        hi_sec  = hclr && ds_e && (fn_e == tsp_pkg::FIELD_SIZE);
        hi_diff = hclr && ds_e && (fn_e == tsp_pkg::FIELD_THIRD);
        lo_sec  = lclr && ds1 && (fn1 == tsp_pkg::FIELD_SIZE);
        lo_diff = lclr && ds1 && (fn1 == tsp_pkg::FIELD_THIRD);
        found   = hi_end || (lo_in && l1.is_dot);

        req_next.clr     = s_first_byte;
        req_next.emit    = act && (found || s_last_byte);
        req_next.found   = found;
        req_next.sec_cnt = {1'b0, hi_sec} + {1'b0, lo_sec};
        if (hi_diff) begin
            req_next.diff_a = tv_e;
            req_next.diff_b = sv_e;
        end else if (lo_diff) begin
            req_next.diff_a = tv1;
            req_next.diff_b = sv1;
        end else begin
            req_next.diff_a = '0;
            req_next.diff_b = '0;
        end

        finished_next     = fin_e || req_next.emit;
        entry_count_next  = lo_cnt ? ec1 + tsp_pkg::entry_t'(1) : ec1;
        field_number_next = lo_in ? l1.field_next : fn1;
        digit_seen_next   = ds1 || (lo_in && l1.is_digit);
        second_value_next = lclr ? '0 : field_update(sv_base, h_sec, l_sec, l0.digit, l1.digit);
        third_value_next  = lclr ? '0 : field_update(tv_base, h_thd, l_thd, l0.digit, l1.digit);

        if (accept) begin
            req_valid_next = 1'b1;
        end else if (req_take) begin
            req_valid_next = 1'b0;
        end else begin
            req_valid_next = req_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            finished_reg     <= 1'b0;
            entry_count_reg  <= '0;
            field_number_reg <= tsp_pkg::FIELD_SIZE;
            second_value_reg <= '0;
            third_value_reg  <= '0;
            digit_seen_reg   <= 1'b0;
            req_valid_reg    <= 1'b0;
        end else begin
            req_valid_reg <= req_valid_next;
            if (accept) begin
                finished_reg     <= finished_next;
                entry_count_reg  <= entry_count_next;
                field_number_reg <= field_number_next;
                second_value_reg <= second_value_next;
                third_value_reg  <= third_value_next;
                digit_seen_reg   <= digit_seen_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= req_next;
        end
    end

endmodule

// ===== rtl/core/tsp_accum.sv =====
// Addend stage, size accumulator and output register.
module tsp_accum (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              req_valid,
    input  tsp_pkg::add_req_t req,
    output logic              req_take,
    input  logic [4:0]        sector_size_code,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [63:0]       m_file_size,
    output logic              m_found
);

    logic          p2_valid_reg, p2_valid_next;
    logic          p2_clr_reg, p2_emit_reg, p2_found_reg;
    tsp_pkg::val_t p2_addend_reg, addend_next;
    tsp_pkg::val_t size_total_reg, size_total_next;
    logic          m_valid_reg, m_valid_next;
    tsp_pkg::val_t m_file_size_reg;
    logic          m_found_reg;
    tsp_pkg::val_t sector, sector_sum;
    logic          c_take, p2_free;

    assign c_take   = p2_valid_reg && (!p2_emit_reg || !m_valid_reg || m_ready);
    assign p2_free  = !p2_valid_reg || c_take;
    assign req_take = req_valid && p2_free;

    always_comb begin
        sector = tsp_pkg::val_t'(tsp_pkg::SECTOR_BASE) << sector_size_code;
        unique case (req.sec_cnt)
            2'd1:    sector_sum = sector;
            2'd2:    sector_sum = sector << 1;
            default: sector_sum = '0;
        endcase
        addend_next     = (req.diff_a - req.diff_b) + sector_sum;
        size_total_next = (p2_clr_reg ? '0 : size_total_reg) + p2_addend_reg;

        if (req_take) begin
            p2_valid_next = 1'b1;
        end else if (c_take) begin
            p2_valid_next = 1'b0;
        end else begin
            p2_valid_next = p2_valid_reg;
        end

        if (c_take && p2_emit_reg) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            size_total_reg <= '0;
        end else begin
            p2_valid_reg <= p2_valid_next;
            m_valid_reg  <= m_valid_next;
            if (c_take) begin
                size_total_reg <= size_total_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req_take) begin
            p2_clr_reg    <= req.clr;
            p2_emit_reg   <= req.emit;
            p2_found_reg  <= req.found;
            p2_addend_reg <= addend_next;
        end
        if (c_take && p2_emit_reg) begin
            m_file_size_reg <= size_total_next;
            m_found_reg     <= p2_found_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_file_size = m_file_size_reg;
    assign m_found     = m_found_reg;

endmodule

// ===== rtl/core/extent_table_size_parser_top.sv =====
// Top level of the extent-table size parser: config registers, parse lanes, accumulator.
// Throughput: one table word per cycle; a result waiting on m_ready holds the input back.
// Result path: the word ending the entry passes the parse, addend and output registers in
//   order; the accepting edge loads the first, and m_valid rises with the output register.
// Reset: aresetn is synchronous, active low; it clears all entry state, the running size,
//   the pipeline valids and both config registers. No clearing pass follows reset.
module extent_table_size_parser_top (
    input  logic        aclk,
    input  logic        aresetn,
    // config write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    // table word input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_table_byte,
    input  logic        s_first_byte,
    input  logic        s_last_byte,
    // result output
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_file_size,
    output logic        m_found
);

    logic [4:0]        sector_size_code_reg;
    logic [15:0]       target_entry_reg;
    logic              req_valid, req_take;
    tsp_pkg::add_req_t req;

    // Hold the registers; the user must write them only while no word is in flight (not enforced here).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sector_size_code_reg <= '0;
            target_entry_reg     <= '0;
        end else if (cfg_we) begin
            unique case (tsp_pkg::cfg_idx_t'(cfg_index))
                tsp_pkg::CFG_SECTOR_SIZE_CODE: sector_size_code_reg <= cfg_wdata[4:0];
                tsp_pkg::CFG_TARGET_ENTRY:     target_entry_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Parse stage: both symbols of a word are decoded side by side, the merge
    // resolves entry skipping, field advance and digit accumulation in one step,
    // and hands the size contribution of the word downstream.
    tsp_parse u_parse (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_table_byte (s_table_byte),
        .s_first_byte (s_first_byte),
        .s_last_byte  (s_last_byte),
        .target_entry (target_entry_reg),
        .req_valid    (req_valid),
        .req          (req),
        .req_take     (req_take)
    );

    // Addend and accumulate stages; a finished result waits in the output
    // register while new words keep flowing through the parse stage.
    tsp_accum u_accum (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .req_valid        (req_valid),
        .req              (req),
        .req_take         (req_take),
        .sector_size_code (sector_size_code_reg),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_file_size      (m_file_size),
        .m_found          (m_found)
    );

endmodule

// ===== rtl/core/tsp_checker.sv =====
// Port-level checks of the extent-table size parser and their bind to the top level.
module tsp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_file_size,
    input logic        m_found
);

    // reset drops any pending result
    a_reset_clears_out: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result still valid after reset");

    // reset empties the pipeline, so input is open right after
    a_reset_opens_in: assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("input not ready after reset");

    // only a blocked output may back-pressure the input
    a_ready_when_out_free: assert property (@(posedge aclk)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input stalled while output is free");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_file_size) && $stable(m_found)))
        else $error("stalled result changed");

    // s_valid is part of the port bundle watched here
    a_in_known: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !$isunknown(s_ready))
        else $error("input ready unknown after a word");

endmodule

bind extent_table_size_parser_top tsp_checker u_tsp_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_file_size (m_file_size),
    .m_found     (m_found)
);

// ===== bench/testbench.sv =====
// Self-checking bench for the extent-table size parser: directed table walk, then random tables.
module testbench;
    import tsp_pkg::*;

    // Pipeline depth from the top-level header: the parse, addend and output registers.
    localparam int LATENCY        = 3;
    // Receiver hold-off long enough to back the block up into its input.
    localparam int HOLD_CYCLES    = 400;
    // Cycles with no word moving on either channel before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int N_PHASES       = 6;

    // Symbols that the package does not name.
    localparam sym_t SYM_DASH  = 4'd10;
    localparam sym_t SYM_SPACE = 4'd14;

    typedef struct packed {
        logic [7:0] tbyte;
        logic       first;
        logic       last;
    } table_word_t;

    typedef struct packed {
        val_t size;
        logic found;
    } size_result_t;

    typedef enum logic {
        ROW_WORD,
        ROW_REG
    } row_kind_t;

    typedef struct {
        row_kind_t    kind;
        cfg_idx_t     idx;
        logic [15:0]  value;
        table_word_t  w;
        logic         typed;
        logic         t_hit;
        size_result_t t_res;
    } script_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_table_byte;
    logic        s_first_byte;
    logic        s_last_byte;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_file_size;
    logic        m_found;

    extent_table_size_parser_top uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_table_byte (s_table_byte),
        .s_first_byte (s_first_byte),
        .s_last_byte  (s_last_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_file_size  (m_file_size),
        .m_found      (m_found)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Size predictor: its own copy of the registers and the entry state.
    // ------------------------------------------------------------------
    logic [4:0] sector_code;
    entry_t     want_entry;

    entry_t ent_count;
    field_t fld;
    val_t   sec_val;
    val_t   thr_val;
    logic   saw_digit;
    val_t   run_total;
    logic   entry_done;

    // Sizes the block still owes, oldest first.
    size_result_t sizes_due[$];
    int           fail_count = 0;

    // Idling knobs, in percent, set per phase.
    int gap_pct   = 0;
    int stall_pct = 0;

    // Bumped by the stimulus to ask the receiver for one long hold-off.
    int hold_requests = 0;

    script_row_t script[$];

    function automatic void clear_entry_state();
        ent_count  = '0;
        fld        = FIELD_SIZE;
        sec_val    = '0;
        thr_val    = '0;
        saw_digit  = 1'b0;
        run_total  = '0;
        entry_done = 1'b0;
    endfunction

    // Feed one symbol; true when it closes the wanted entry.
    function automatic logic parse_symbol(input sym_t s);
        val_t digit;
        if (entry_done) return 1'b0;
        // Skip whole entries ahead of the wanted one by counting dots.
        if (ent_count != want_entry) begin
            if (s == SYM_DOT) ent_count = ent_count + 1'b1;
            return 1'b0;
        end
        if (s == SYM_COMMA || s == SYM_DOT) begin
            if (saw_digit) begin
                if (fld == FIELD_SIZE) begin
                    run_total = run_total + (val_t'(SECTOR_BASE) << sector_code);
                end else if (fld == FIELD_THIRD) begin
                    run_total = run_total + (thr_val - sec_val);
                end
            end
            fld     = FIELD_SIZE;
            sec_val = '0;
            thr_val = '0;
            return s == SYM_DOT;
        end
        if (s == SYM_SEMI) begin
            if (fld != FIELD_LAST) fld = fld + 2'd1;
            return 1'b0;
        end
        // Anything else is a digit; dash and space weigh zero.
        saw_digit = 1'b1;
        digit = (s <= SYM_NINE) ? val_t'(s) : '0;
        if (fld == FIELD_SECOND) begin
            sec_val = sec_val * 10 + digit;
        end else if (fld == FIELD_THIRD) begin
            thr_val = thr_val * 10 + digit;
        end
        return 1'b0;
    endfunction

    // Advance the predictor by one table word; true when the word yields a size.
    function automatic logic size_after_word(input table_word_t w, output size_result_t r);
        sym_t hi;
        sym_t lo;
        logic hit;
        r = '0;
        if (w.first) clear_entry_state();
        if (entry_done) return 1'b0;
        hi = '0;
        lo = '0;
        if (w.tbyte < PAIR_LIMIT) begin
            hi = sym_t'(w.tbyte / SYMS_PER_DIGIT);
            lo = sym_t'(w.tbyte % SYMS_PER_DIGIT);
        end
        // A dot in the upper symbol that closes the wanted entry drops the lower one.
        hit = parse_symbol(hi);
        if (!hit) hit = parse_symbol(lo);
        if (hit || w.last) begin
            entry_done = 1'b1;
            r.size     = run_total;
            r.found    = hit;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Directed script builders.
    // ------------------------------------------------------------------
    function automatic void add_word(input logic [7:0] b, input logic f, input logic l);
        script_row_t r;
        r.kind  = ROW_WORD;
        r.idx   = CFG_SECTOR_SIZE_CODE;
        r.value = '0;
        r.w     = '{tbyte: b, first: f, last: l};
        r.typed = 1'b0;
        r.t_hit = 1'b0;
        r.t_res = '0;
        script.push_back(r);
    endfunction

    function automatic void add_typed(input logic [7:0] b, input logic f, input logic l,
                                      input logic hit, input val_t size, input logic found);
        add_word(b, f, l);
        script[$].typed = 1'b1;
        script[$].t_hit = hit;
        script[$].t_res = '{size: size, found: found};
    endfunction

    function automatic void add_reg(input cfg_idx_t idx, input logic [15:0] value);
        script_row_t r;
        r.kind  = ROW_REG;
        r.idx   = idx;
        r.value = value;
        r.w     = '0;
        r.typed = 1'b0;
        r.t_hit = 1'b0;
        r.t_res = '0;
        script.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus tasks.
    // ------------------------------------------------------------------

    // Drop valid and hold until every owed size has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sizes_due.size() != 0);
    endtask

    // Write one register while the block is idle.
    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
        wait_drained();
        // Let any word that ends without a result clear the pipeline.
        repeat (LATENCY + 2) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_SECTOR_SIZE_CODE) begin
            sector_code = value[4:0];
        end else begin
            want_entry = entry_t'(value);
        end
    endtask

    // Offer one word, hold it until taken, then log what it should produce.
    task automatic send_word(input table_word_t w, input logic typed, input logic t_hit,
                             input size_result_t t_res);
        logic         hit;
        size_result_t r;
        if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < gap_pct);
        end
        s_valid      <= 1'b1;
        s_table_byte <= w.tbyte;
        s_first_byte <= w.first;
        s_last_byte  <= w.last;
        do @(posedge aclk); while (!s_ready);
        hit = size_after_word(w, r);
        if (typed) begin
            if (t_hit) sizes_due.push_back(t_res);
        end else if (hit) begin
            sizes_due.push_back(r);
        end
    endtask

    // Build one well-formed table aimed at the wanted entry, sometimes cut short.
    task automatic make_table(output table_word_t words[$]);
        sym_t        syms[$];
        int          n_entries;
        int          n_ext;
        int          n_fld;
        int          n_dig;
        int          cut;
        sym_t        hi;
        sym_t        lo;
        table_word_t w;
        words = {};
        if (want_entry > 8) begin
            n_entries = $urandom_range(1, 3);
        end else if ($urandom_range(99) < 15) begin
            n_entries = $urandom_range(0, want_entry);
        end else begin
            n_entries = want_entry + $urandom_range(1, 2);
        end
        for (int e = 0; e < n_entries; e++) begin
            // Keep the skipped entries short; load the wanted one.
            n_ext = (e == want_entry) ? $urandom_range(0, 3) : $urandom_range(0, 1);
            for (int x = 0; x < n_ext; x++) begin
                if (x > 0) syms.push_back(SYM_COMMA);
                n_fld = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 3;
                for (int f = 0; f < n_fld; f++) begin
                    if (f > 0) syms.push_back(SYM_SEMI);
                    // Now and then a long run of digits to wrap the field values.
                    n_dig = ($urandom_range(19) == 0) ? $urandom_range(12, 24)
                                                      : $urandom_range(0, 3);
                    for (int d = 0; d < n_dig; d++) begin
                        if ($urandom_range(19) == 0) begin
                            syms.push_back($urandom_range(1) ? SYM_DASH : SYM_SPACE);
                        end else begin
                            syms.push_back(sym_t'($urandom_range(0, 9)));
                        end
                    end
                end
            end
            syms.push_back(SYM_DOT);
        end
        // Truncate some tables so they end inside an entry.
        if (syms.size() > 1 && $urandom_range(9) == 0) begin
            cut = $urandom_range(1, syms.size() - 1);
            while (syms.size() > cut) void'(syms.pop_back());
        end
        if (syms.size() % 2 != 0 || syms.size() == 0) syms.push_back(SYM_SPACE);
        if (syms.size() % 2 != 0) syms.push_back(SYM_SPACE);
        for (int i = 0; i < syms.size(); i += 2) begin
            hi = syms[i];
            lo = syms[i + 1];
            // A double zero may also travel as one of the out-of-range bytes.
            if (hi == 0 && lo == 0 && $urandom_range(1)) begin
                w.tbyte = 8'($urandom_range(PAIR_LIMIT, 255));
            end else begin
                w.tbyte = 8'(hi * SYMS_PER_DIGIT + lo);
            end
            w.first = (i == 0);
            w.last  = (i + 2 >= syms.size()) && ($urandom_range(9) != 0);
            words.push_back(w);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: check each size word and drive ready.
    // ------------------------------------------------------------------
    int hold_seen = 0;
    int hold_left = 0;

    always @(posedge aclk) begin
        size_result_t due;
        if (aresetn && m_valid && m_ready) begin
            if (sizes_due.size() == 0) begin
                $display("%0t: size word with nothing pending: file_size %h found %b",
                         $time, m_file_size, m_found);
                fail_count++;
            end else begin
                due = sizes_due.pop_front();
                if (m_file_size !== due.size) begin
                    $display("%0t: file_size expected %h, got %h",
                             $time, due.size, m_file_size);
                    fail_count++;
                end
                if (m_found !== due.found) begin
                    $display("%0t: found expected %b, got %b", $time, due.found, m_found);
                    fail_count++;
                end
            end
        end
        // Start a long hold-off when the stimulus asks for one.
        if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);
        end
    end

    // Watchdog: end the run if no word moves on either side for too long.
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    logic [15:0] phase_code[N_PHASES]   = '{16'd0, 16'd9, 16'hFFF7, 16'd31, 16'd5, 16'd1};
    logic [15:0] phase_target[N_PHASES] = '{16'd0, 16'd1, 16'd3, 16'd2, 16'hFFFF, 16'd0};
    int          phase_words[N_PHASES]  = '{130, 120, 130, 120, 70, 130};
    int          phase_gap[N_PHASES]    = '{0, 64, 0, 19, 19, 0};
    int          phase_stall[N_PHASES]  = '{0, 0, 64, 19, 19, 0};

    initial begin
        table_word_t words[$];
        table_word_t w;
        int          sent;
        int          n_noise;
        logic        paused;

        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_SECTOR_SIZE_CODE;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_table_byte = '0;
        s_first_byte = 1'b0;
        s_last_byte  = 1'b0;
        sector_code  = '0;
        want_entry   = '0;
        clear_entry_state();

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table, reset registers first: sector 512, entry zero.
        add_typed(8'd192, 1'b1, 1'b0, 1'b1, 64'd0, 1'b1);     // ".." with no digit adds nothing
        add_typed(8'd255, 1'b1, 1'b1, 1'b1, 64'd0, 1'b0);     // table ends inside the entry
        add_typed(8'd225, 1'b1, 1'b0, 1'b0, 64'd0, 1'b0);     // high byte reads as "00"
        add_typed(8'd194, 1'b0, 1'b0, 1'b1, 64'd512, 1'b1);   // ". " adds one sector
        add_typed(8'd0,   1'b0, 1'b1, 1'b0, 64'd0, 1'b0);     // ignored after a result
        add_word(8'd28,  1'b1, 1'b0);                         // "1;" "2;" "5." -> third minus second
        add_word(8'd43,  1'b0, 1'b0);
        add_word(8'd87,  1'b0, 1'b0);
        add_word(8'd13,  1'b1, 1'b0);                         // "0;" "9;" "0." -> wraps below zero
        add_word(8'd148, 1'b0, 1'b0);
        add_word(8'd12,  1'b0, 1'b0);
        add_word(8'd208, 1'b1, 1'b0);                         // ";;" ";;" saturate the field number
        add_word(8'd208, 1'b0, 1'b0);
        add_word(8'd146, 1'b0, 1'b0);                         // "9," in the last field adds nothing
        add_word(8'd189, 1'b0, 1'b0);                         // ".9" drops the trailing digit
        add_word(8'd28,  1'b1, 1'b0);                         // dash and space weigh zero
        add_word(8'd154, 1'b0, 1'b0);
        add_word(8'd209, 1'b0, 1'b0);
        add_word(8'd117, 1'b0, 1'b0);
        add_reg(CFG_SECTOR_SIZE_CODE, 16'd31);                // largest code the register holds
        add_reg(CFG_TARGET_ENTRY, 16'd5);
        add_word(8'd193, 1'b1, 1'b0);                         // ".;" skips entry zero
        add_typed(8'd112, 1'b0, 1'b1, 1'b1, 64'd0, 1'b0);     // wanted entry never reached
        add_reg(CFG_TARGET_ENTRY, 16'd1);
        add_word(8'd187, 1'b1, 1'b0);                         // ".7" then ",." adds the sector twice
        add_word(8'd177, 1'b0, 1'b0);
        add_typed(8'd224, 1'b1, 1'b1, 1'b1, 64'd0, 1'b0);     // all-space word, entry one not reached

        foreach (script[i]) begin
            if (script[i].kind == ROW_REG) begin
                write_reg(script[i].idx, script[i].value);
            end else begin
                send_word(script[i].w, script[i].typed, script[i].t_hit, script[i].t_res);
            end
        end
        wait_drained();

        // Random phases: one register setting and one idling pattern each.
        for (int p = 0; p < N_PHASES; p++) begin
            write_reg(CFG_SECTOR_SIZE_CODE, phase_code[p]);
            write_reg(CFG_TARGET_ENTRY, phase_target[p]);
            gap_pct   = phase_gap[p];
            stall_pct = phase_stall[p];
            sent      = 0;
            paused    = 1'b0;
            while (sent < phase_words[p]) begin
                // Halfway through: back up the block once, else drain it dry.
                if (!paused && sent >= phase_words[p] / 2) begin
                    paused = 1'b1;
                    if (p == 0) begin
                        hold_requests++;
                    end else begin
                        wait_drained();
                    end
                end
                if ($urandom_range(99) < 15) begin
                    // Noise: loose words with arbitrary flags.
                    n_noise = $urandom_range(1, 5);
                    words   = {};
                    for (int k = 0; k < n_noise; k++) begin
                        w.tbyte = 8'($urandom_range(0, 255));
                        w.first = 1'($urandom_range(1));
                        w.last  = ($urandom_range(3) == 0);
                        words.push_back(w);
                    end
                end else begin
                    make_table(words);
                end
                foreach (words[k]) begin
                    send_word(words[k], 1'b0, 1'b0, '0);
                end
                sent += words.size();
            end
            wait_drained();
        end

        repeat (LATENCY * 4) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
